// ----- sv/hashed_split_bucket_chooser_assert.svh -----
// Assertion macros shared by the split bucket chooser RTL
`ifndef HASHED_SPLIT_BUCKET_CHOOSER_ASSERT_SVH
`define HASHED_SPLIT_BUCKET_CHOOSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define HSBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsbc assertion failed");

// Next-cycle implication, sampled on clk, off while in reset
`define HSBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsbc assertion failed");

`endif

// ----- sv/hsbc_pkg.sv -----
// Shared constants, types and hash function of the split bucket chooser
`timescale 1ns / 1ps
package hsbc_pkg;

  localparam int HASH_W = 32;
  localparam int BYTE_W = 8;
  localparam int WGT_W  = 8;
  localparam int BKT_W  = 10;
  localparam int CLS_W  = 2;
  localparam int IDX_W  = 2;
  localparam int CNT_W  = 5;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

  localparam logic [WGT_W-1:0] WEIGHT_TRAIN_RST = 8'd8;
  localparam logic [WGT_W-1:0] WEIGHT_VAL_RST   = 8'd1;
  localparam logic [WGT_W-1:0] WEIGHT_TEST_RST  = 8'd1;

  // Register indexes of the config port
  localparam logic [IDX_W-1:0] REG_WEIGHT_TRAIN = 2'd0;
  localparam logic [IDX_W-1:0] REG_WEIGHT_VAL   = 2'd1;
  localparam logic [IDX_W-1:0] REG_WEIGHT_TEST  = 2'd2;

  // Split class codes
  localparam logic [CLS_W-1:0] CLS_TRAIN = 2'd0;
  localparam logic [CLS_W-1:0] CLS_VAL   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_TEST  = 2'd2;

  // Control from the top level to the modulo unit
  typedef struct packed {
    logic start;
    logic take;
  } mod_ctl_t;

  // Status from the modulo unit to the top level
  typedef struct packed {
    logic idle;
    logic done;
  } mod_sts_t;

  // Fold one byte into the running FNV-1a hash
  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    return x * FNV_PRIME;
  endfunction

endpackage

// ----- sv/hsbc_mod.sv -----
// Bit-serial restoring modulo unit: 32-bit hash modulo a 10-bit total
`timescale 1ns / 1ps
module hsbc_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hsbc_pkg::mod_ctl_t          ctl,
  input  logic [hsbc_pkg::HASH_W-1:0] dividend,
  input  logic [hsbc_pkg::BKT_W-1:0]  divisor,
  output hsbc_pkg::mod_sts_t          sts,
  output logic [hsbc_pkg::BKT_W-1:0]  remainder
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_DONE
  } mod_state_t;

  mod_state_t                    state_r, state_nxt;
  logic [hsbc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [hsbc_pkg::HASH_W-1:0]   quo_r, quo_nxt;
  logic [hsbc_pkg::BKT_W-1:0]    rem_r, rem_nxt;
  logic [hsbc_pkg::BKT_W-1:0]    div_r, div_nxt;
  logic [hsbc_pkg::BKT_W:0]      trial;
  logic [hsbc_pkg::BKT_W:0]      diff;
  logic                          fits;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[hsbc_pkg::HASH_W-1]};
    diff  = trial - {1'b0, div_r};
    fits  = (trial >= {1'b0, div_r});
  end

  // Sequence the steps
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    case (state_r)
      M_IDLE: begin
        if (ctl.start) begin
          quo_nxt = dividend;
          div_nxt = divisor;
          rem_nxt = '0;
          cnt_nxt = '0;
          // zero total gives bucket zero without iterating
          state_nxt = (divisor == '0) ? M_DONE : M_RUN;
        end
      end
      M_RUN: begin
        rem_nxt = fits ? diff[hsbc_pkg::BKT_W-1:0] : trial[hsbc_pkg::BKT_W-1:0];
        quo_nxt = {quo_r[hsbc_pkg::HASH_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = M_DONE;
        end
      end
      M_DONE: begin
        if (ctl.take) begin
          state_nxt = M_IDLE;
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  // Hold state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign sts.idle  = (state_r == M_IDLE);
  assign sts.done  = (state_r == M_DONE);
  assign remainder = rem_r;

endmodule

// ----- sv/hashed_split_bucket_chooser.sv -----
// Top level: FNV-1a string hash, modulo bucket and train/val/test split
//
// Bytes of an identifier string arrive one per transfer on the in_ channel; each
// byte is folded into a 32-bit FNV-1a hash (offset basis 0x811C9DC5, prime
// 16777619) in the cycle it is taken. The byte flagged in_is_last starts a
// bit-serial modulo unit that divides the final hash by weight_train +
// weight_val + weight_test one dividend bit per cycle: in_ready stays low
// after that byte through the 32 divide steps and a handover state (only the
// handover state when all weights are zero), and for as long as the result
// waits for the output register to free up.
// The result (split class, hash, bucket)
// is held in an output register until taken; the next string's bytes may
// stream in meanwhile until its own last byte. Weights are written on the
// cfg_ channel (index 0 train, 1 validation, 2 test, index 3 ignored) and
// must only change while no string end is in flight.
`timescale 1ns / 1ps
`include "hashed_split_bucket_chooser_assert.svh"
module hashed_split_bucket_chooser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hsbc_pkg::BYTE_W-1:0] in_char_byte,
  input  logic                        in_is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hsbc_pkg::CLS_W-1:0]  out_split_class,
  output logic [hsbc_pkg::HASH_W-1:0] out_hash_word,
  output logic [hsbc_pkg::BKT_W-1:0]  out_bucket_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hsbc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [hsbc_pkg::WGT_W-1:0]  cfg_data
);

  logic [hsbc_pkg::WGT_W-1:0]  wgt_train_r, wgt_train_nxt;
  logic [hsbc_pkg::WGT_W-1:0]  wgt_val_r, wgt_val_nxt;
  logic [hsbc_pkg::WGT_W-1:0]  wgt_test_r, wgt_test_nxt;
  logic [hsbc_pkg::HASH_W-1:0] hash_r, hash_nxt;
  logic [hsbc_pkg::HASH_W-1:0] final_r, final_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [hsbc_pkg::CLS_W-1:0]  cls_r, cls_nxt;
  logic [hsbc_pkg::HASH_W-1:0] out_hash_r, out_hash_nxt;
  logic [hsbc_pkg::BKT_W-1:0]  bkt_r, bkt_nxt;

  logic                        in_xfer;
  logic                        cfg_xfer;
  logic [hsbc_pkg::HASH_W-1:0] folded;
  logic [hsbc_pkg::BKT_W-1:0]  total;
  logic [hsbc_pkg::WGT_W:0]    edge_val;
  logic [hsbc_pkg::BKT_W-1:0]  rem;
  hsbc_pkg::mod_ctl_t          ctl;
  hsbc_pkg::mod_sts_t          sts;

  assign in_ready  = sts.idle;
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign folded    = hsbc_pkg::fnv_fold(hash_r, in_char_byte);

  // Bucket total and class boundaries
  assign total = {2'b00, wgt_train_r} + {2'b00, wgt_val_r} + {2'b00, wgt_test_r};
  assign edge_val = {1'b0, wgt_train_r} + {1'b0, wgt_val_r};

  // Start the modulo on the last byte, hand its result over when the slot frees
  assign ctl.start = in_xfer && in_is_last;
  assign ctl.take  = sts.done && (!out_valid_r || out_ready);

  hsbc_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .dividend  (folded),
    .divisor   (total),
    .sts       (sts),
    .remainder (rem)
  );

  // Config register writes
  always_comb begin
    wgt_train_nxt = wgt_train_r;
    wgt_val_nxt   = wgt_val_r;
    wgt_test_nxt  = wgt_test_r;
    if (cfg_xfer) begin
      case (cfg_index)
        hsbc_pkg::REG_WEIGHT_TRAIN: wgt_train_nxt = cfg_data;
        hsbc_pkg::REG_WEIGHT_VAL:   wgt_val_nxt   = cfg_data;
        hsbc_pkg::REG_WEIGHT_TEST:  wgt_test_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Fold bytes; restart from the offset basis after the last one
  always_comb begin
    hash_nxt  = hash_r;
    final_nxt = final_r;
    if (in_xfer) begin
      if (in_is_last) begin
        hash_nxt  = hsbc_pkg::FNV_BASIS;
        final_nxt = folded;
      end else begin
        hash_nxt = folded;
      end
    end
  end

  // Output register: load on handover, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    cls_nxt       = cls_r;
    out_hash_nxt  = out_hash_r;
    bkt_nxt       = bkt_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.take) begin
      out_valid_nxt = 1'b1;
      out_hash_nxt  = final_r;
      bkt_nxt       = rem;
      if (rem < {2'b00, wgt_train_r}) begin
        cls_nxt = hsbc_pkg::CLS_TRAIN;
      end else if (rem < {1'b0, edge_val}) begin
        cls_nxt = hsbc_pkg::CLS_VAL;
      end else begin
        cls_nxt = hsbc_pkg::CLS_TEST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wgt_train_r <= hsbc_pkg::WEIGHT_TRAIN_RST;
      wgt_val_r   <= hsbc_pkg::WEIGHT_VAL_RST;
      wgt_test_r  <= hsbc_pkg::WEIGHT_TEST_RST;
      hash_r      <= hsbc_pkg::FNV_BASIS;
      out_valid_r <= 1'b0;
    end else begin
      wgt_train_r <= wgt_train_nxt;
      wgt_val_r   <= wgt_val_nxt;
      wgt_test_r  <= wgt_test_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
    final_r    <= final_nxt;
    cls_r      <= cls_nxt;
    out_hash_r <= out_hash_nxt;
    bkt_r      <= bkt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_split_class  = cls_r;
  assign out_hash_word    = out_hash_r;
  assign out_bucket_index = bkt_r;

  // Last byte blocks further input while the modulo runs
  `HSBC_ASSERT_NEXT(a_last_blocks, in_xfer && in_is_last, !in_ready)
  // Hash restarts from the offset basis after a string ends
  `HSBC_ASSERT_NEXT(a_hash_restart, in_xfer && in_is_last, hash_r == hsbc_pkg::FNV_BASIS)
  // A nonzero total always yields a bucket below it
  `HSBC_ASSERT_SAME(a_bucket_range, out_valid_r && (total != '0), bkt_r < total)
  // No new result is loaded over one that has not been taken
  `HSBC_ASSERT_SAME(a_no_overwrite, ctl.take && out_valid_r, out_ready)

endmodule
